// ===== sv/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants for the binary min-heap queue: sizes, opcode and
// status codes, controller states, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   localparam int CAPACITY  = 256;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int CNT_W     = ADDR_W + 1;
   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 32;
   localparam int STATUS_W  = 2;

   typedef enum logic {
      OP_INSERT  = 1'b0,
      OP_EXTRACT = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_EXTRACTED = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_DROPPED   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EX_RD,
      S_DN_RD,
      S_DN_CMP,
      S_UP_RD,
      S_UP_CMP,
      S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // transaction accepted, latch and classify it
      logic ex_take;   // root and last entry are in the read registers
      logic up_rd;     // read parent of current slot
      logic up_move;   // parent moves down into current slot
      logic dn_rd;     // read both children of current slot
      logic dn_move;   // picked child moves up into current slot
      logic wr_moved;  // moving entry lands in current slot
      logic rsp_load;  // result goes to the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cnt_zero;
      logic cnt_full;
      logic pos_zero;
      logic left_out;  // current slot has no child
      logic up_stop;   // moving key >= parent key
      logic dn_stop;   // picked child key >= moving key
      logic rsp_busy;  // output register holds a transaction that is stalled
   } sts_type;

endpackage

// ===== sv/bmhq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Controller state machine: accepts one transaction at a time and steps the
// datapath through sift-up or sift-down, one heap level per read state and compare state.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_opcode,
   output logic                 req_stall,
   input  bmhq_pkg::sts_type    sts,
   output bmhq_pkg::cmd_type    cmd
);

   bmhq_pkg::state_type state_ff;
   bmhq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmhq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         bmhq_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_opcode == bmhq_pkg::OP_INSERT) begin
                  state_in = sts.cnt_full ? bmhq_pkg::S_DONE : bmhq_pkg::S_UP_RD;
               end else begin
                  state_in = sts.cnt_zero ? bmhq_pkg::S_DONE : bmhq_pkg::S_EX_RD;
               end
            end
         end
         bmhq_pkg::S_EX_RD: begin
            cmd.ex_take = 1'b1;
            // count is already decremented: nothing left to re-seat
            state_in = sts.cnt_zero ? bmhq_pkg::S_DONE : bmhq_pkg::S_DN_RD;
         end
         bmhq_pkg::S_DN_RD: begin
            if (sts.left_out) begin
               cmd.wr_moved = 1'b1;
               state_in     = bmhq_pkg::S_DONE;
            end else begin
               cmd.dn_rd = 1'b1;
               state_in  = bmhq_pkg::S_DN_CMP;
            end
         end
         bmhq_pkg::S_DN_CMP: begin
            if (sts.dn_stop) begin
               cmd.wr_moved = 1'b1;
               state_in     = bmhq_pkg::S_DONE;
            end else begin
               cmd.dn_move = 1'b1;
               state_in    = bmhq_pkg::S_DN_RD;
            end
         end
         bmhq_pkg::S_UP_RD: begin
            if (sts.pos_zero) begin
               cmd.wr_moved = 1'b1;
               state_in     = bmhq_pkg::S_DONE;
            end else begin
               cmd.up_rd = 1'b1;
               state_in  = bmhq_pkg::S_UP_CMP;
            end
         end
         bmhq_pkg::S_UP_CMP: begin
            if (sts.up_stop) begin
               cmd.wr_moved = 1'b1;
               state_in     = bmhq_pkg::S_DONE;
            end else begin
               cmd.up_move = 1'b1;
               state_in    = bmhq_pkg::S_UP_RD;
            end
         end
         bmhq_pkg::S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = bmhq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bmhq_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/bmhq_dp.sv =====
// ----------------------------------------------------------------------------
// bmhq_dp
// Datapath: heap storage (one write port, two registered read ports), entry
// count, slot pointer, moving entry, compares, and the output register.
// ----------------------------------------------------------------------------
module bmhq_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  bmhq_pkg::cmd_type                 cmd,
   output bmhq_pkg::sts_type                 sts,
   input  logic                              req_opcode,
   input  logic [bmhq_pkg::KEY_W-1:0]        req_new_key,
   input  logic [bmhq_pkg::PAYLOAD_W-1:0]    req_new_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bmhq_pkg::STATUS_W-1:0]     rsp_status,
   output logic [bmhq_pkg::KEY_W-1:0]        rsp_out_key,
   output logic [bmhq_pkg::PAYLOAD_W-1:0]    rsp_out_payload,
   output logic [bmhq_pkg::CNT_W-1:0]        rsp_occupancy
);

   localparam int ADDR_W = bmhq_pkg::ADDR_W;
   localparam int CNT_W  = bmhq_pkg::CNT_W;
   localparam int KEY_W  = bmhq_pkg::KEY_W;
   localparam int PAY_W  = bmhq_pkg::PAYLOAD_W;

   // heap storage
   logic [KEY_W-1:0]  heap_key_ff [bmhq_pkg::CAPACITY];
   logic [PAY_W-1:0]  heap_pay_ff [bmhq_pkg::CAPACITY];
   logic [KEY_W-1:0]  rd_a_key_ff, rd_b_key_ff;
   logic [PAY_W-1:0]  rd_a_pay_ff, rd_b_pay_ff;
   logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
   logic              wr_en;
   logic [KEY_W-1:0]  wr_key;
   logic [PAY_W-1:0]  wr_pay;

   // control state of the walk
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [PAY_W-1:0]  pay_ff, pay_in;

   // pending result
   bmhq_pkg::status_type res_status_ff, res_status_in;
   logic [KEY_W-1:0]  res_key_ff, res_key_in;
   logic [PAY_W-1:0]  res_pay_ff, res_pay_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [bmhq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [KEY_W-1:0]  rsp_key_ff;
   logic [PAY_W-1:0]  rsp_pay_ff;
   logic [CNT_W-1:0]  rsp_occ_ff;

   // tree arithmetic
   logic [CNT_W-1:0]  left_idx;
   logic [CNT_W:0]    right_idx;
   logic [ADDR_W-1:0] parent_idx;
   logic              right_ok;
   logic              pick_right;
   logic [KEY_W-1:0]  pick_key;
   logic [PAY_W-1:0]  pick_pay;
   logic [ADDR_W-1:0] pick_idx;
   logic              cnt_zero, cnt_full;

   assign cnt_zero   = (count_ff == '0);
   assign cnt_full   = (count_ff == CNT_W'(bmhq_pkg::CAPACITY));
   assign left_idx   = {pos_ff, 1'b1};
   assign right_idx  = {1'b0, left_idx} + (CNT_W+1)'(1);
   assign parent_idx = (pos_ff - ADDR_W'(1)) >> 1;
   assign right_ok   = right_idx < {1'b0, count_ff};
   // equal child keys go right
   assign pick_right = right_ok && !(rd_a_key_ff < rd_b_key_ff);
   assign pick_key   = pick_right ? rd_b_key_ff : rd_a_key_ff;
   assign pick_pay   = pick_right ? rd_b_pay_ff : rd_a_pay_ff;
   assign pick_idx   = pick_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];

   always_comb begin
      sts          = '0;
      sts.cnt_zero = cnt_zero;
      sts.cnt_full = cnt_full;
      sts.pos_zero = (pos_ff == '0);
      sts.left_out = left_idx >= count_ff;
      sts.up_stop  = key_ff >= rd_a_key_ff;
      sts.dn_stop  = pick_key >= key_ff;
      sts.rsp_busy = rsp_valid_ff && rsp_stall;
   end

   // read addresses: at accept, root and last live entry
   always_comb begin
      rd_a_addr = '0;
      rd_b_addr = ADDR_W'(count_ff - CNT_W'(1));
      if (cmd.up_rd) begin
         rd_a_addr = parent_idx;
      end else if (cmd.dn_rd) begin
         rd_a_addr = left_idx[ADDR_W-1:0];
         rd_b_addr = right_idx[ADDR_W-1:0];
      end
   end

   always_comb begin
      wr_en  = cmd.wr_moved | cmd.up_move | cmd.dn_move;
      wr_key = pick_key;
      wr_pay = pick_pay;
      if (cmd.wr_moved) begin
         wr_key = key_ff;
         wr_pay = pay_ff;
      end else if (cmd.up_move) begin
         wr_key = rd_a_key_ff;
         wr_pay = rd_a_pay_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_key_ff[pos_ff] <= wr_key;
         heap_pay_ff[pos_ff] <= wr_pay;
      end
      rd_a_key_ff <= heap_key_ff[rd_a_addr];
      rd_a_pay_ff <= heap_pay_ff[rd_a_addr];
      rd_b_key_ff <= heap_key_ff[rd_b_addr];
      rd_b_pay_ff <= heap_pay_ff[rd_b_addr];
   end

   always_comb begin
      count_in      = count_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_pay_in    = res_pay_ff;
      if (cmd.load) begin
         key_in     = req_new_key;
         pay_in     = req_new_payload;
         res_key_in = '0;
         res_pay_in = '0;
         if (req_opcode == bmhq_pkg::OP_INSERT) begin
            if (cnt_full) begin
               res_status_in = bmhq_pkg::ST_DROPPED;
            end else begin
               res_status_in = bmhq_pkg::ST_INSERTED;
               pos_in        = count_ff[ADDR_W-1:0];
               count_in      = count_ff + CNT_W'(1);
            end
         end else begin
            if (cnt_zero) begin
               res_status_in = bmhq_pkg::ST_EMPTY;
            end else begin
               res_status_in = bmhq_pkg::ST_EXTRACTED;
               count_in      = count_ff - CNT_W'(1);
            end
         end
      end
      if (cmd.ex_take) begin
         res_key_in = rd_a_key_ff;
         res_pay_in = rd_a_pay_ff;
         key_in     = rd_b_key_ff;
         pay_in     = rd_b_pay_ff;
         pos_in     = '0;
      end
      if (cmd.up_move) begin
         pos_in = parent_idx;
      end
      if (cmd.dn_move) begin
         pos_in = pick_idx;
      end
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_pay_ff    <= res_pay_in;
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_key_ff    <= res_key_ff;
         rsp_pay_ff    <= res_pay_ff;
         rsp_occ_ff    <= count_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_payload = rsp_pay_ff;
   assign rsp_occupancy   = rsp_occ_ff;

   // count stays within the heap
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(bmhq_pkg::CAPACITY))
      else $error("entry count above capacity");

   // a result never overwrites a stalled one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   // a live extract takes exactly one entry off
   a_extract_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && req_opcode == bmhq_pkg::OP_EXTRACT && !cnt_zero)
      |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("extract did not decrement count");

   // only one write source per cycle
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wr_moved, cmd.up_move, cmd.dn_move}))
      else $error("conflicting heap writes");

endmodule

// ===== sv/binary_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Binary min-heap priority queue: insert with sift-up, extract-min with
// sift-down, keys unsigned 32 bit, one result per transaction.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  opcode, new_key, new_payload
//  rsp      out        rsp_valid/rsp_stall  status, out_key, out_payload, occupancy
//
//  one transaction at a time: an insert reads and compares once per level climbed, an
//  extract once per level descended, a dropped insert or empty extract walks no level;
//  an insert at 256 entries climbs at most 8 levels, each level waiting on one
//  registered heap read; a result waits in DONE while the output register is stalled
//  reset clears the entry count and the controller, heap storage is not swept
//  a stalled result waits in the output register while the next walk runs
// ----------------------------------------------------------------------------
module binary_min_heap_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [bmhq_pkg::KEY_W-1:0]        req_new_key,
   input  logic [bmhq_pkg::PAYLOAD_W-1:0]    req_new_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bmhq_pkg::STATUS_W-1:0]     rsp_status,
   output logic [bmhq_pkg::KEY_W-1:0]        rsp_out_key,
   output logic [bmhq_pkg::PAYLOAD_W-1:0]    rsp_out_payload,
   output logic [bmhq_pkg::CNT_W-1:0]        rsp_occupancy
);

   bmhq_pkg::cmd_type cmd;
   bmhq_pkg::sts_type sts;

   bmhq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   bmhq_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_opcode      (req_opcode),
      .req_new_key     (req_new_key),
      .req_new_payload (req_new_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_payload (rsp_out_payload),
      .rsp_occupancy   (rsp_occupancy)
   );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary min-heap queue. A clocked driver feeds
// insert/extract transactions from a queue and a clocked monitor checks every
// result against a shadow heap kept in the bench, field by field. The run goes
// through directed corner cases, a long receiver hold-off, a fill to capacity
// with dropped inserts and a partial drain at full rate.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 40;

   typedef struct {
      bmhq_pkg::opcode_type                 op;
      logic [bmhq_pkg::KEY_W-1:0]           key;
      logic [bmhq_pkg::PAYLOAD_W-1:0]       payload;
   } heap_op_type;

   typedef struct {
      bmhq_pkg::status_type                 status;
      logic [bmhq_pkg::KEY_W-1:0]           key;
      logic [bmhq_pkg::PAYLOAD_W-1:0]       payload;
      logic [bmhq_pkg::CNT_W-1:0]           occupancy;
   } heap_result_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic                                 req_opcode = 1'b0;
   logic [bmhq_pkg::KEY_W-1:0]           req_new_key = '0;
   logic [bmhq_pkg::PAYLOAD_W-1:0]       req_new_payload = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic [bmhq_pkg::STATUS_W-1:0]        rsp_status;
   logic [bmhq_pkg::KEY_W-1:0]           rsp_out_key;
   logic [bmhq_pkg::PAYLOAD_W-1:0]       rsp_out_payload;
   logic [bmhq_pkg::CNT_W-1:0]           rsp_occupancy;

   binary_min_heap_queue uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_new_key     (req_new_key),
      .req_new_payload (req_new_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_payload (rsp_out_payload),
      .rsp_occupancy   (rsp_occupancy)
   );

   always #10 clock = ~clock;

   // shadow heap
   logic [bmhq_pkg::KEY_W-1:0]     shadow_key [bmhq_pkg::CAPACITY];
   logic [bmhq_pkg::PAYLOAD_W-1:0] shadow_payload [bmhq_pkg::CAPACITY];
   int                             shadow_count = 0;

   heap_op_type     pending_ops[$];
   heap_result_type pending_results[$];

   int  send_idle_pct = 15;
   int  recv_stall_pct = 74;
   bit  hold_arm = 1'b0;
   bit  hold_taken = 1'b0;
   int  hold_left = 0;
   bit  req_accepted = 1'b0;
   int  gen_count = 0;

   int  mismatches = 0;
   int  results_seen = 0;
   int  status_seen [4] = '{0, 0, 0, 0};
   int  peak_occupancy = 0;
   int  input_stall_cycles = 0;

   function automatic heap_result_type heap_apply(heap_op_type t);
      heap_result_type                r;
      int                             pos;
      int                             parent;
      int                             left;
      int                             pick;
      logic [bmhq_pkg::KEY_W-1:0]     mk;
      logic [bmhq_pkg::PAYLOAD_W-1:0] mp;
      r.key = '0;
      r.payload = '0;
      if (t.op == bmhq_pkg::OP_INSERT) begin
         if (shadow_count >= bmhq_pkg::CAPACITY) begin
            r.status = bmhq_pkg::ST_DROPPED;
         end else begin
            pos = shadow_count;
            shadow_count++;
            while (pos > 0) begin
               parent = (pos - 1) >> 1;
               if (t.key >= shadow_key[parent]) break;
               shadow_key[pos] = shadow_key[parent];
               shadow_payload[pos] = shadow_payload[parent];
               pos = parent;
            end
            shadow_key[pos] = t.key;
            shadow_payload[pos] = t.payload;
            r.status = bmhq_pkg::ST_INSERTED;
         end
      end else if (shadow_count == 0) begin
         r.status = bmhq_pkg::ST_EMPTY;
      end else begin
         r.key = shadow_key[0];
         r.payload = shadow_payload[0];
         shadow_count--;
         if (shadow_count > 0) begin
            mk = shadow_key[shadow_count];
            mp = shadow_payload[shadow_count];
            pos = 0;
            while (1) begin
               left = 2 * pos + 1;
               if (left >= shadow_count) break;
               pick = left;
               // equal children: right one wins
               if (left + 1 < shadow_count && !(shadow_key[left] < shadow_key[left + 1]))
                  pick = left + 1;
               if (shadow_key[pick] >= mk) break;
               shadow_key[pos] = shadow_key[pick];
               shadow_payload[pos] = shadow_payload[pick];
               pos = pick;
            end
            shadow_key[pos] = mk;
            shadow_payload[pos] = mp;
         end
         r.status = bmhq_pkg::ST_EXTRACTED;
      end
      r.occupancy = shadow_count[bmhq_pkg::CNT_W-1:0];
      return r;
   endfunction

   task automatic flag_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // driver: new transaction only when the line is free or was just taken
   always @(negedge clock) begin
      heap_op_type t;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            t = pending_ops.pop_front();
            req_valid <= 1'b1;
            req_opcode <= t.op;
            req_new_key <= t.key;
            req_new_payload <= t.payload;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_arm && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // monitor: check results first so a same-edge request cannot match them
   always @(posedge clock) begin
      heap_op_type     t;
      heap_result_type want;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            status_seen[rsp_status]++;
            if (int'(rsp_occupancy) > peak_occupancy) peak_occupancy = int'(rsp_occupancy);
            if (pending_results.size() == 0) begin
               flag_mismatch($sformatf("result status %0d with no transaction pending",
                                       rsp_status));
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch($sformatf("status %0d, expected %0d",
                                          rsp_status, want.status));
               if (rsp_out_key !== want.key)
                  flag_mismatch($sformatf("out_key %h, expected %h",
                                          rsp_out_key, want.key));
               if (rsp_out_payload !== want.payload)
                  flag_mismatch($sformatf("out_payload %h, expected %h",
                                          rsp_out_payload, want.payload));
               if (rsp_occupancy !== want.occupancy)
                  flag_mismatch($sformatf("occupancy %0d, expected %0d",
                                          rsp_occupancy, want.occupancy));
            end
         end
         if (req_valid && req_stall) input_stall_cycles++;
         if (req_valid && !req_stall) begin
            t.op = bmhq_pkg::opcode_type'(req_opcode);
            t.key = req_new_key;
            t.payload = req_new_payload;
            pending_results.push_back(heap_apply(t));
            req_accepted <= 1'b1;
         end else begin
            req_accepted <= 1'b0;
         end
      end
   end

   task automatic push_op(bmhq_pkg::opcode_type op, logic [bmhq_pkg::KEY_W-1:0] k,
                          logic [bmhq_pkg::PAYLOAD_W-1:0] p);
      heap_op_type t;
      t.op = op;
      t.key = k;
      t.payload = p;
      pending_ops.push_back(t);
      if (op == bmhq_pkg::OP_INSERT && gen_count < bmhq_pkg::CAPACITY) gen_count++;
      if (op == bmhq_pkg::OP_EXTRACT && gen_count > 0) gen_count--;
   endtask

   // mix of full range, a narrow band for ties, and the extremes
   function automatic logic [bmhq_pkg::KEY_W-1:0] rand_key();
      case ($urandom_range(3))
         0: return bmhq_pkg::KEY_W'($urandom_range(15));
         1: return $urandom_range(1) ? '1 : '0;
         default: return $urandom;
      endcase
   endfunction

   task automatic wait_drained();
      while (pending_ops.size() != 0 || req_valid || pending_results.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners: empty extract, extremes, ties, equal children
      push_op(bmhq_pkg::OP_EXTRACT, $urandom, $urandom);
      push_op(bmhq_pkg::OP_INSERT, '1, '1);
      push_op(bmhq_pkg::OP_INSERT, '0, '0);
      push_op(bmhq_pkg::OP_EXTRACT, $urandom, $urandom);
      push_op(bmhq_pkg::OP_INSERT, 32'd1, 32'h11);
      push_op(bmhq_pkg::OP_INSERT, 32'd7, 32'h71);
      push_op(bmhq_pkg::OP_INSERT, 32'd7, 32'h72);
      push_op(bmhq_pkg::OP_INSERT, 32'd7, 32'h73);
      push_op(bmhq_pkg::OP_INSERT, 32'h7f80_0000, 32'h5a5a_5a5a);
      repeat (7) push_op(bmhq_pkg::OP_EXTRACT, $urandom, $urandom);
      push_op(bmhq_pkg::OP_INSERT, 32'd9, 32'hA5A5_A5A5);
      push_op(bmhq_pkg::OP_INSERT, 32'd9, 32'h5A5A_5A5A);
      push_op(bmhq_pkg::OP_INSERT, 32'd9, 32'hFFFF_0000);
      repeat (3) push_op(bmhq_pkg::OP_EXTRACT, $urandom, $urandom);
      // sender pause until every result is back
      wait_drained();

      // mixed traffic with a long receiver hold-off
      hold_arm = 1'b1;
      repeat (60) begin
         if ($urandom_range(99) < 60) push_op(bmhq_pkg::OP_INSERT, rand_key(), $urandom);
         else push_op(bmhq_pkg::OP_EXTRACT, $urandom, $urandom);
      end
      while (pending_ops.size() != 0) @(posedge clock);

      // fill to capacity, then dropped inserts
      send_idle_pct = 74;
      recv_stall_pct = 15;
      while (gen_count < bmhq_pkg::CAPACITY) begin
         if ($urandom_range(99) < 95) push_op(bmhq_pkg::OP_INSERT, rand_key(), $urandom);
         else push_op(bmhq_pkg::OP_EXTRACT, $urandom, $urandom);
      end
      repeat (3) push_op(bmhq_pkg::OP_INSERT, rand_key(), $urandom);
      while (pending_ops.size() != 0) @(posedge clock);

      // partial drain at full rate
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (90) begin
         if ($urandom_range(99) < 90) push_op(bmhq_pkg::OP_EXTRACT, $urandom, $urandom);
         else push_op(bmhq_pkg::OP_INSERT, rand_key(), $urandom);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));

      $display("checked %0d results: %0d inserted, %0d extracted, %0d empty, %0d dropped",
               results_seen, status_seen[bmhq_pkg::ST_INSERTED],
               status_seen[bmhq_pkg::ST_EXTRACTED], status_seen[bmhq_pkg::ST_EMPTY],
               status_seen[bmhq_pkg::ST_DROPPED]);
      $display("peak occupancy %0d, input stalled %0d cycles, %0d mismatches",
               peak_occupancy, input_stall_cycles, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout, %0d results still expected", pending_results.size());
      $display("FAIL");
      $finish;
   end

endmodule
